// ----- design/pnq_pkg.sv -----
// shared constants, codes and types of the peak normalizer
package pnq_pkg;

  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned VAL_W    = 17;
  localparam int unsigned Q_SHIFT  = 16;
  localparam int unsigned SCALE_W  = 31;
  localparam int unsigned PROD_W   = VAL_W + SCALE_W + 1;

  // dividend of the scale division: full scale in q16
  localparam logic [SCALE_W-1:0] FULL_SCALE_Q = SCALE_W'(64'd32767 << Q_SHIFT);
  localparam int unsigned DIV_STEPS  = SCALE_W;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_DROP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_FETCH,
    OP_EMPTY,
    OP_DROP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic                first;
    logic                last;
    logic [ADDR_W-1:0]   addr;
    logic [VAL_W-1:0]    peak;
  } q_entry_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [VAL_W-1:0]    data;
  } ram_wr_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_OUT
  } back_state_t;

endpackage

// ----- design/pnq_ram.sv -----
// generic simple dual-port ram with registered read
module pnq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/pnq_front.sv -----
// front end: takes transfers, stores loads, tracks the peak and queues work for the back end
module pnq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,
  input  logic              s_tuser,
  input  logic              q_full,
  input  logic              back_pending,
  output logic              q_push,
  output pnq_pkg::q_entry_t q_data,
  output pnq_pkg::ram_wr_t  ram_wr
);
  import pnq_pkg::*;

  logic              channel_mode;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] rd_idx, rd_idx_next;
  logic [VAL_W-1:0]  peak, peak_next;
  logic              emitting, emitting_next;

  logic [VAL_W-1:0]  value;
  logic [VAL_W-1:0]  mag;
  logic [ADDR_W-1:0] idx;
  logic              is_last;
  logic              store_full;
  logic              accept;

  always_comb begin
    if (channel_mode) begin
      value = {s_tdata[SAMPLE_W-1], s_tdata[SAMPLE_W-1:0]};
    end else begin
      value = {s_tdata[SAMPLE_W-1], s_tdata[SAMPLE_W-1:0]}
            + {s_tdata[2*SAMPLE_W-1], s_tdata[2*SAMPLE_W-1:SAMPLE_W]};
    end
    mag        = value[VAL_W-1] ? (~value + VAL_W'(1)) : value;
    idx        = emitting ? rd_idx : '0;
    is_last    = (CNT_W'(idx) + CNT_W'(1)) == count;
    store_full = count == CNT_W'(STORE_DEPTH);

    // loads after a finished block wait until pending fetches have read the store
    s_tready = !q_full && !(back_pending && !emitting);
    accept   = s_tvalid && s_tready;

    count_next    = count;
    rd_idx_next   = rd_idx;
    peak_next     = peak;
    emitting_next = emitting;
    q_push        = 1'b0;
    q_data.kind   = OP_FETCH;
    q_data.first  = !emitting;
    q_data.last   = is_last;
    q_data.addr   = idx;
    q_data.peak   = peak;
    ram_wr.en     = 1'b0;
    ram_wr.addr   = count[ADDR_W-1:0];
    ram_wr.data   = value;

    if (accept) begin
      if (s_tuser == CMD_LOAD) begin
        if (!emitting) begin
          if (store_full) begin
            q_push      = 1'b1;
            q_data.kind = OP_DROP;
          end else begin
            ram_wr.en  = 1'b1;
            count_next = count + CNT_W'(1);
            if (mag > peak) begin
              peak_next = mag;
            end
          end
        end
      end else if (count == '0) begin
        q_push      = 1'b1;
        q_data.kind = OP_EMPTY;
      end else begin
        q_push = 1'b1;
        if (is_last) begin
          count_next    = '0;
          rd_idx_next   = '0;
          peak_next     = VAL_W'(1);
          emitting_next = 1'b0;
        end else begin
          rd_idx_next   = idx + ADDR_W'(1);
          emitting_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mode <= 1'b0;
      count        <= '0;
      rd_idx       <= '0;
      peak         <= VAL_W'(1);
      emitting     <= 1'b0;
    end else begin
      if (cfg_we) begin
        channel_mode <= cfg_data;
      end
      count    <= count_next;
      rd_idx   <= rd_idx_next;
      peak     <= peak_next;
      emitting <= emitting_next;
    end
  end

endmodule

// ----- design/pnq_fifo.sv -----
// short work queue between front end and back end
module pnq_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pnq_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output pnq_pkg::q_entry_t pop_data,
  output logic              empty
);
  import pnq_pkg::*;

  q_entry_t          entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full     = fill == QCNT_W'(Q_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- design/pnq_div.sv -----
// restoring divider, one quotient bit per cycle, computes the q16 scale
module pnq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pnq_pkg::VAL_W-1:0]   divisor,
  output logic                        done,
  output logic [pnq_pkg::SCALE_W-1:0] quotient
);
  import pnq_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [VAL_W-1:0]      rem;
  logic [VAL_W-1:0]      dvs;
  logic [VAL_W:0]        rem_sh;
  logic [VAL_W:0]        diff;
  logic                  ge;

  always_comb begin
    rem_sh = {rem, quotient[SCALE_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + DIV_STEP_W'(1);
        if (step == DIV_STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= FULL_SCALE_Q;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SCALE_W-2:0], ge};
      rem      <= ge ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
    end
  end

endmodule

// ----- design/pnq_back.sv -----
// back end: reads stored values, scales them, reports empty and drop status and holds the output register
module pnq_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  pnq_pkg::q_entry_t          q_data,
  output logic                       q_pop,
  output logic                       ram_rd_en,
  output logic [pnq_pkg::ADDR_W-1:0] ram_rd_addr,
  input  logic [pnq_pkg::VAL_W-1:0]  ram_rd_data,
  output logic                       busy,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,
  output logic                       m_tlast,
  output logic [1:0]                 m_tuser
);
  import pnq_pkg::*;

  back_state_t             state, state_next;
  q_entry_t                cur;
  logic signed [PROD_W-1:0] prod;
  logic                    div_start;
  logic                    div_done;
  logic [SCALE_W-1:0]      scale;
  logic                    out_load;

  pnq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (q_data.peak),
    .done     (div_done),
    .quotient (scale)
  );

  assign ram_rd_addr = q_data.addr;
  assign busy        = state != B_IDLE;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_rd_en  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.kind == OP_FETCH) begin
            ram_rd_en = 1'b1;
            if (q_data.first) begin
              div_start  = 1'b1;
              state_next = B_DIV;
            end else begin
              state_next = B_MUL;
            end
          end else begin
            state_next = B_OUT;
          end
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        state_next = B_OUT;
      end
      B_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (state == B_MUL) begin
      prod <= $signed(ram_rd_data) * $signed({1'b0, scale});
    end
    if (out_load) begin
      unique case (cur.kind)
        OP_FETCH: begin
          m_tdata <= prod[Q_SHIFT +: SAMPLE_W];
          m_tlast <= cur.last;
          m_tuser <= STATUS_OK;
        end
        OP_EMPTY: begin
          m_tdata <= '0;
          m_tlast <= 1'b0;
          m_tuser <= STATUS_EMPTY;
        end
        default: begin
          m_tdata <= '0;
          m_tlast <= 1'b0;
          m_tuser <= STATUS_DROP;
        end
      endcase
    end
  end

endmodule

// ----- design/peak_normalizer_q16_unit.sv -----
// top level of the two-pass q16 peak normalizer
//
// channel   dir  payload (low bit first)                      transfer when
// cfg       in   cfg_data: channel_mode                       cfg_we high
// s_axis    in   tdata: sample_a, sample_b; tuser: command    s_tvalid & s_tready
// m_axis    out  tdata: sample_out; tlast: last_out;          m_tvalid & m_tready
//                tuser: status
//
// a load is written to the store by the front end; a fetch passes the queue and
// then the back end steps through store read, multiply and output register
// the first fetch of a block also waits for the serial scale division
// while no block is emitting, transfers wait until queued work has drained
// the value store needs no clearing pass, so the block accepts right after rst
// either side may stall: the two-entry queue and the output register decouple them
module peak_normalizer_q16_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_we,
  input  logic        cfg_data,     // channel_mode: 0 stereo sum, 1 mono
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // [15:0] sample_a, [31:16] sample_b
  input  logic        s_tuser,      // command: 0 load, 1 fetch
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // [15:0] sample_out
  output logic        m_tlast,      // last_out
  output logic [1:0]  m_tuser       // status: 0 ok, 1 nothing stored, 2 dropped
);
  import pnq_pkg::*;

  // queue between front and back
  q_entry_t          q_push_data;
  q_entry_t          q_pop_data;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  // store ports
  ram_wr_t           ram_wr;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [VAL_W-1:0]  ram_rd_data;

  logic              back_busy;
  logic              back_pending;

  // any queued or running work may still read the store
  assign back_pending = back_busy || !q_empty;

  pnq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .q_full       (q_full),
    .back_pending (back_pending),
    .q_push       (q_push),
    .q_data       (q_push_data),
    .ram_wr       (ram_wr)
  );

  pnq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // value store: one joined or mono value per load
  pnq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pnq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .busy        (back_busy),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

// ----- tb/tb_peak_normalizer_q16_unit.sv -----
// self-checking testbench of the two-pass q16 peak normalizer
module tb_peak_normalizer_q16_unit;
  import pnq_pkg::*;

  localparam int CYCLE_LIMIT  = 1200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 48;       // fetch path plus the serial division
  localparam int END_CYCLES   = 60;
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int MAX_PRINT    = 200;
  localparam int PHASE_ITEMS  = 150;
  localparam int PHASES       = 5;

  // one expected output transfer
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    status_t     status;
  } norm_result_t;

  // mirror of the normalizer state plus the queue of outstanding results
  class norm_scoreboard;
    norm_result_t expected_q[$];
    int           store_val[STORE_DEPTH];
    int unsigned  count;
    int unsigned  rd_idx;
    int unsigned  peak;
    longint       scale;
    bit           emitting;
    bit           mode;
    int           errors;

    function new();
      mode   = 1'b0;
      errors = 0;
      clear_block();
    endfunction

    function void clear_block();
      count    = 0;
      rd_idx   = 0;
      peak     = 1;
      scale    = 0;
      emitting = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // runs one accepted input through the model; returns 0 for an ignored load
    function bit note_input(logic cmd, logic signed [15:0] a, logic signed [15:0] b);
      int           v;
      int unsigned  mag;
      longint       prod;
      norm_result_t r;
      if (cmd == CMD_LOAD) begin
        if (emitting) return 1'b0;
        if (count >= STORE_DEPTH) begin
          r.sample = '0;
          r.last   = 1'b0;
          r.status = STATUS_DROP;
          expected_q.push_back(r);
          return 1'b1;
        end
        v = mode ? int'(a) : int'(a) + int'(b);
        store_val[count] = v;
        count++;
        mag = (v < 0) ? -v : v;
        if (mag > peak) peak = mag;
        return 1'b1;
      end
      if (count == 0) begin
        r.sample = '0;
        r.last   = 1'b0;
        r.status = STATUS_EMPTY;
        expected_q.push_back(r);
        return 1'b1;
      end
      if (!emitting) begin
        scale    = (longint'(32767) << 16) / longint'(peak);
        rd_idx   = 0;
        emitting = 1'b1;
      end
      prod     = longint'(store_val[rd_idx]) * scale;
      r.sample = 16'(prod >>> 16);
      r.status = STATUS_OK;
      rd_idx++;
      r.last = (rd_idx >= count);
      if (r.last) clear_block();
      expected_q.push_back(r);
      return 1'b1;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINT) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic [15:0] data, logic last, logic [1:0] user);
      norm_result_t r;
      if (expected_q.size() == 0) begin
        report("result transfer with no expectation outstanding");
        return;
      end
      r = expected_q.pop_front();
      if (data !== r.sample)
        report($sformatf("sample_out %0d, expected %0d", $signed(data), $signed(r.sample)));
      if (last !== r.last)
        report($sformatf("last_out %0b, expected %0b", last, r.last));
      if (user !== r.status)
        report($sformatf("status %0d, expected %0d", user, r.status));
    endtask
  endclass

  // clock, reset and block inputs, all known from time zero
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic        cfg_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  norm_scoreboard sb = new();

  int cycles       = 0;
  int random_items = 0;
  bit no_idle      = 1'b0;   // stretch with no gaps on either side
  bit hold_start   = 1'b0;   // asks the receiver for one long hold-off
  int hold_left    = 0;
  int stall_left   = 0;

  peak_normalizer_q16_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sample values lean toward the extremes, otherwise any 16-bit pattern
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: ready changes at the falling edge, random stalls and one long hold
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  // every result transfer is checked at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offers one item; entered and left at a falling edge, valid stays up
  // between back-to-back items so it never drops and rises in one step
  task automatic send_item(input logic cmd, input logic [15:0] a, input logic [15:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {b, a};
    do @(posedge clk); while (!s_tready);
    if (sb.note_input(cmd, a, b)) random_items++;
    @(negedge clk);
  endtask

  // channel_mode is only written with nothing in flight
  task automatic write_mode(input logic m);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // a load leaves no result behind, so give the block time to settle
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.mode = m;
  endtask

  // one block: loads then fetches, with stray loads, short fetch runs and
  // fetches on an empty block mixed in
  task automatic run_block();
    int n;
    int nf;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    no_idle = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) send_item(CMD_LOAD, rand_sample(), rand_sample());
    nf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < nf; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(CMD_LOAD, rand_sample(), rand_sample());
      send_item(CMD_FETCH, rand_sample(), rand_sample());
    end
    if ($urandom_range(0, 5) == 0) send_item(CMD_FETCH, rand_sample(), rand_sample());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stereo: fetch on empty, full-scale sums, a load while emitting
    write_mode(1'b0);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_LOAD,  16'h7fff, 16'h7fff);
    send_item(CMD_LOAD,  16'h8000, 16'h8000);
    send_item(CMD_LOAD,  16'h0000, 16'h0000);
    send_item(CMD_LOAD,  16'hffff, 16'h0000);
    send_item(CMD_FETCH, 16'hffff, 16'hffff);
    send_item(CMD_LOAD,  16'h1234, 16'h4321);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);

    // mono: single-value block with the peak left at one, then the extremes
    write_mode(1'b1);
    send_item(CMD_LOAD,  16'h0001, 16'hffff);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_LOAD,  16'h0000, 16'h8000);
    send_item(CMD_LOAD,  16'hffff, 16'h7fff);
    send_item(CMD_LOAD,  16'h7fff, 16'h5a5a);
    send_item(CMD_LOAD,  16'h8000, 16'ha5a5);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_LOAD,  16'h7fff, 16'h7fff);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);
    send_item(CMD_FETCH, 16'h0000, 16'h0000);

    // random phases, both modes
    random_items = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_mode((p == PHASES - 1) ? 1'($urandom_range(0, 1)) : 1'(p % 2));
      if (p == 0) begin
        // receiver holds off while fetches keep coming, so the input stalls
        for (int i = 0; i < 24; i++) send_item(CMD_LOAD, rand_sample(), rand_sample());
        hold_start = 1'b1;
        for (int i = 0; i < 24; i++) send_item(CMD_FETCH, rand_sample(), rand_sample());
      end
      while (random_items < (p + 1) * PHASE_ITEMS) run_block();
    end

    // drain and let the block settle before the verdict
    s_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- peak_normalizer_q16_unit.f -----
design/pnq_pkg.sv
design/pnq_ram.sv
design/pnq_front.sv
design/pnq_fifo.sv
design/pnq_div.sv
design/pnq_back.sv
design/peak_normalizer_q16_unit.sv
tb/tb_peak_normalizer_q16_unit.sv
